// File: hw/rtl/mtp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the MessagePack token parser.
// No dependencies; every file of the block but the two interfaces uses this package.
package mtp_pkg;

	typedef enum logic [3:0] {
		K_NIL   = 4'd0,
		K_BOOL  = 4'd1,
		K_UINT  = 4'd2,
		K_SINT  = 4'd3,
		K_FLOAT = 4'd4,
		K_CHUNK = 4'd5,
		K_ARRAY = 4'd6,
		K_MAP   = 4'd7,
		K_BIN   = 4'd8,
		K_STR   = 4'd9,
		K_EXT   = 4'd10
	} kind_t;

	typedef enum logic [1:0] {
		PH_HEAD,
		PH_FIELD,
		PH_EXT,
		PH_PAY
	} phase_t;

	// What a byte asks for if it turns out to be a header
	typedef enum logic [1:0] {
		ACT_EMIT,
		ACT_BAD,
		ACT_FIELD,
		ACT_FIXEXT
	} act_t;

	localparam logic [7:0] HDR_FIXMAP     = 8'h80;
	localparam logic [7:0] HDR_FIXARRAY   = 8'h90;
	localparam logic [7:0] HDR_FIXSTR     = 8'ha0;
	localparam logic [7:0] HDR_NIL        = 8'hc0;
	localparam logic [7:0] HDR_UNUSED     = 8'hc1;
	localparam logic [7:0] HDR_FALSE      = 8'hc2;
	localparam logic [7:0] HDR_TRUE       = 8'hc3;
	localparam logic [7:0] HDR_BIN8       = 8'hc4;
	localparam logic [7:0] HDR_EXT8       = 8'hc7;
	localparam logic [7:0] HDR_FLOAT_BASE = 8'hc8;
	localparam logic [7:0] HDR_FLOAT32    = 8'hca;
	localparam logic [7:0] HDR_UINT8      = 8'hcc;
	localparam logic [7:0] HDR_INT8       = 8'hd0;
	localparam logic [7:0] HDR_FIXEXT1    = 8'hd4;
	localparam logic [7:0] HDR_STR8       = 8'hd9;
	localparam logic [7:0] HDR_ARRAY_BASE = 8'hdb;
	localparam logic [7:0] HDR_ARRAY16    = 8'hdc;
	localparam logic [7:0] HDR_MAP_BASE   = 8'hdd;
	localparam logic [7:0] HDR_MAP16      = 8'hde;
	localparam logic [7:0] HDR_NEGFIX     = 8'he0;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		act_t        act;
		kind_t       kind;
		logic [5:0]  imm_len;
		logic [7:0]  imm_val;
		logic        start_pay;
		logic [4:0]  nbytes;
	} hdr_t;

	typedef struct packed {
		logic [7:0] data;
		hdr_t       hdr;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} qbeat_t;

	typedef struct packed {
		kind_t       kind;
		logic [32:0] length;
		logic [63:0] value_bits;
		logic [7:0]  ext_code;
		logic [7:0]  chunk_byte;
		logic        chunk_last;
		logic        bad_header;
	} tok_t;

endpackage

// File: hw/rtl/mtp_bytes_if.sv
`timescale 1ns / 1ps
// Byte channel into the token parser: valid/ready plus one stream byte.
// No dependencies.
interface mtp_bytes_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

// File: hw/rtl/mtp_tokens_if.sv
`timescale 1ns / 1ps
// Token channel out of the parser: valid/ready plus the token fields.
// No dependencies.
interface mtp_tokens_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [32:0] length;
	logic [63:0] value_bits;
	logic [7:0]  ext_code;
	logic [7:0]  chunk_byte;
	logic        chunk_last;
	logic        bad_header;

	modport source(output valid, output kind, output length, output value_bits,
		output ext_code, output chunk_byte, output chunk_last, output bad_header,
		input ready);
	modport sink(input valid, input kind, input length, input value_bits,
		input ext_code, input chunk_byte, input chunk_last, input bad_header,
		output ready);
endinterface

// File: hw/rtl/mtp_front.sv
`timescale 1ns / 1ps
// Front stage: accepts stream bytes and pre-decodes each as a header byte.
// Depends on mtp_pkg and mtp_bytes_if.
module mtp_front (
	input  logic          clk,
	input  logic          arst_n,
	mtp_bytes_if.sink     bytes,
	output mtp_pkg::qbeat_t qpush,
	input  logic          q_ready
);

	function automatic mtp_pkg::hdr_t decode(input logic [7:0] b);
		mtp_pkg::hdr_t h;
		logic [2:0]    sh;
		h.act       = mtp_pkg::ACT_EMIT;
		h.kind      = mtp_pkg::K_NIL;
		h.imm_len   = '0;
		h.imm_val   = '0;
		h.start_pay = 1'b0;
		h.nbytes    = '0;
		sh          = '0;
		if (b < mtp_pkg::HDR_FIXMAP) begin
			h.kind    = mtp_pkg::K_UINT;
			h.imm_len = 6'd1;
			h.imm_val = b;
		end else if (b < mtp_pkg::HDR_FIXARRAY) begin
			h.kind    = mtp_pkg::K_MAP;
			h.imm_len = {1'b0, b[3:0], 1'b0};
		end else if (b < mtp_pkg::HDR_FIXSTR) begin
			h.kind    = mtp_pkg::K_ARRAY;
			h.imm_len = {2'b00, b[3:0]};
		end else if (b < mtp_pkg::HDR_NIL) begin
			h.kind      = mtp_pkg::K_STR;
			h.imm_len   = {1'b0, b[4:0]};
			h.start_pay = 1'b1;
		end else if (b >= mtp_pkg::HDR_NEGFIX) begin
			h.kind    = mtp_pkg::K_SINT;
			h.imm_len = 6'd1;
			h.imm_val = b;
		end else if (b == mtp_pkg::HDR_NIL) begin
			h.kind = mtp_pkg::K_NIL;
		end else if (b == mtp_pkg::HDR_UNUSED) begin
			h.act = mtp_pkg::ACT_BAD;
		end else if (b == mtp_pkg::HDR_FALSE || b == mtp_pkg::HDR_TRUE) begin
			h.kind    = mtp_pkg::K_BOOL;
			h.imm_len = 6'd1;
			h.imm_val = {7'd0, b[0]};
		end else begin
			h.act = mtp_pkg::ACT_FIELD;
			if (b < mtp_pkg::HDR_EXT8) begin
				h.kind = mtp_pkg::K_BIN;
				sh     = 3'(b - mtp_pkg::HDR_BIN8);
			end else if (b < mtp_pkg::HDR_FLOAT32) begin
				h.kind = mtp_pkg::K_EXT;
				sh     = 3'(b - mtp_pkg::HDR_EXT8);
			end else if (b < mtp_pkg::HDR_UINT8) begin
				h.kind = mtp_pkg::K_FLOAT;
				sh     = 3'(b - mtp_pkg::HDR_FLOAT_BASE);
			end else if (b < mtp_pkg::HDR_INT8) begin
				h.kind = mtp_pkg::K_UINT;
				sh     = 3'(b - mtp_pkg::HDR_UINT8);
			end else if (b < mtp_pkg::HDR_FIXEXT1) begin
				h.kind = mtp_pkg::K_SINT;
				sh     = 3'(b - mtp_pkg::HDR_INT8);
			end else if (b < mtp_pkg::HDR_STR8) begin
				// fixext: length is implied, type byte comes next
				h.act  = mtp_pkg::ACT_FIXEXT;
				h.kind = mtp_pkg::K_EXT;
				sh     = 3'(b - mtp_pkg::HDR_FIXEXT1);
			end else if (b < mtp_pkg::HDR_ARRAY16) begin
				h.kind = mtp_pkg::K_STR;
				sh     = 3'(b - mtp_pkg::HDR_STR8);
			end else if (b < mtp_pkg::HDR_MAP16) begin
				h.kind = mtp_pkg::K_ARRAY;
				sh     = 3'(b - mtp_pkg::HDR_ARRAY_BASE);
			end else begin
				h.kind = mtp_pkg::K_MAP;
				sh     = 3'(b - mtp_pkg::HDR_MAP_BASE);
			end
			h.nbytes = 5'd1 << sh;
		end
		return h;
	endfunction

	logic            valid_s1;
	mtp_pkg::entry_t entry_s1;
	logic            take;
	logic            push;

	assign push        = valid_s1 && q_ready;
	assign bytes.ready = !valid_s1 || q_ready;
	assign take        = bytes.valid && bytes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && !push);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			entry_s1.data <= bytes.in_byte;
			entry_s1.hdr  <= decode(bytes.in_byte);
		end
	end

	assign qpush.valid = valid_s1;
	assign qpush.entry = entry_s1;

endmodule

// File: hw/rtl/mtp_fifo.sv
`timescale 1ns / 1ps
// Short queue of decoded beats between the front stage and the back end.
// Depends on mtp_pkg.
module mtp_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  mtp_pkg::qbeat_t wr,
	output logic            wr_ready,
	output mtp_pkg::qbeat_t rd,
	input  logic            rd_take
);

	mtp_pkg::entry_t             mem_q [mtp_pkg::Q_DEPTH];
	logic [mtp_pkg::Q_AW-1:0]    wptr_q;
	logic [mtp_pkg::Q_AW-1:0]    rptr_q;
	logic [mtp_pkg::Q_CW-1:0]    cnt_q;
	logic                        push;
	logic                        pop;

	assign wr_ready = cnt_q != mtp_pkg::Q_CW'(mtp_pkg::Q_DEPTH);
	assign push     = wr.valid && wr_ready;
	assign pop      = rd_take && rd.valid;
	assign rd.valid = cnt_q != '0;
	assign rd.entry = mem_q[rptr_q];

	function automatic logic [mtp_pkg::Q_AW-1:0] bump(input logic [mtp_pkg::Q_AW-1:0] p);
		return (p == mtp_pkg::Q_AW'(mtp_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= bump(wptr_q);
			if (pop)
				rptr_q <= bump(rptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wr.entry;
	end

endmodule

// File: hw/rtl/mtp_back.sv
`timescale 1ns / 1ps
// Back end: parse state machine, field accumulator, payload counter and
// the output register. Depends on mtp_pkg and mtp_tokens_if.
module mtp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  mtp_pkg::qbeat_t rd,
	output logic            rd_take,
	mtp_tokens_if.source    tokens
);

	mtp_pkg::phase_t phase_q, phase_n;
	mtp_pkg::kind_t  pend_kind_q, pend_kind_n;
	logic [3:0]      left_q, left_n;
	logic [63:0]     acc_q, acc_n;
	logic [32:0]     held_len_q, held_len_n;
	logic [31:0]     pay_left_q, pay_left_n;

	logic            out_valid_q;
	mtp_pkg::tok_t   out_q;
	logic            res_valid;
	mtp_pkg::tok_t   res;

	logic [7:0]      b;
	mtp_pkg::hdr_t   hdr;
	logic [31:0]     len32;
	logic            sign;

	assign b       = rd.entry.data;
	assign hdr     = rd.entry.hdr;
	assign rd_take = rd.valid && (!out_valid_q || tokens.ready);

	always_comb begin
		phase_n     = phase_q;
		pend_kind_n = pend_kind_q;
		left_n      = left_q;
		acc_n       = acc_q;
		held_len_n  = held_len_q;
		pay_left_n  = pay_left_q;
		res_valid   = 1'b0;
		res         = '{kind: mtp_pkg::K_NIL, default: '0};
		len32       = '0;
		sign        = 1'b1;
		case (phase_q)
			mtp_pkg::PH_PAY: begin
				pay_left_n     = pay_left_q - 32'd1;
				res_valid      = 1'b1;
				res.kind       = mtp_pkg::K_CHUNK;
				res.length     = 33'd1;
				res.chunk_byte = b;
				res.chunk_last = pay_left_q == 32'd1;
				if (pay_left_q == 32'd1)
					phase_n = mtp_pkg::PH_HEAD;
			end
			mtp_pkg::PH_FIELD: begin
				acc_n  = {acc_q[55:0], b};
				left_n = left_q - 4'd1;
				len32  = acc_n[31:0];
				if (left_n == 4'd0) begin
					phase_n = mtp_pkg::PH_HEAD;
					case (pend_kind_q)
						mtp_pkg::K_UINT, mtp_pkg::K_FLOAT, mtp_pkg::K_SINT: begin
							// a signed value with its top bit clear reads as unsigned
							case (held_len_q[3:0])
								4'd1:    sign = acc_n[7];
								4'd2:    sign = acc_n[15];
								4'd4:    sign = acc_n[31];
								4'd8:    sign = acc_n[63];
								default: sign = 1'b1;
							endcase
							res_valid      = 1'b1;
							res.kind       = (pend_kind_q == mtp_pkg::K_SINT && !sign) ?
								mtp_pkg::K_UINT : pend_kind_q;
							res.length     = held_len_q;
							res.value_bits = acc_n;
						end
						mtp_pkg::K_EXT: begin
							held_len_n = {1'b0, len32};
							phase_n    = mtp_pkg::PH_EXT;
						end
						mtp_pkg::K_MAP: begin
							res_valid  = 1'b1;
							res.kind   = mtp_pkg::K_MAP;
							res.length = {len32, 1'b0};
						end
						mtp_pkg::K_BIN, mtp_pkg::K_STR: begin
							res_valid  = 1'b1;
							res.kind   = pend_kind_q;
							res.length = {1'b0, len32};
							pay_left_n = len32;
							if (len32 != 32'd0)
								phase_n = mtp_pkg::PH_PAY;
						end
						default: begin
							res_valid  = 1'b1;
							res.kind   = pend_kind_q;
							res.length = {1'b0, len32};
						end
					endcase
				end
			end
			mtp_pkg::PH_EXT: begin
				len32        = held_len_q[31:0];
				res_valid    = 1'b1;
				res.kind     = mtp_pkg::K_EXT;
				res.length   = {1'b0, len32};
				res.ext_code = b;
				pay_left_n   = len32;
				phase_n      = (len32 != 32'd0) ? mtp_pkg::PH_PAY : mtp_pkg::PH_HEAD;
			end
			default: begin
				case (hdr.act)
					mtp_pkg::ACT_EMIT: begin
						res_valid      = 1'b1;
						res.kind       = hdr.kind;
						res.length     = {27'd0, hdr.imm_len};
						res.value_bits = {56'd0, hdr.imm_val};
						if (hdr.start_pay && hdr.imm_len != 6'd0) begin
							pay_left_n = {26'd0, hdr.imm_len};
							phase_n    = mtp_pkg::PH_PAY;
						end
					end
					mtp_pkg::ACT_BAD: begin
						res_valid      = 1'b1;
						res.bad_header = 1'b1;
					end
					mtp_pkg::ACT_FIELD: begin
						pend_kind_n = hdr.kind;
						left_n      = hdr.nbytes[3:0];
						held_len_n  = {28'd0, hdr.nbytes};
						acc_n       = '0;
						phase_n     = mtp_pkg::PH_FIELD;
					end
					default: begin
						pend_kind_n = mtp_pkg::K_EXT;
						held_len_n  = {28'd0, hdr.nbytes};
						phase_n     = mtp_pkg::PH_EXT;
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= mtp_pkg::PH_HEAD;
			pend_kind_q <= mtp_pkg::K_NIL;
			left_q      <= '0;
			acc_q       <= '0;
			held_len_q  <= '0;
			pay_left_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_take) begin
				phase_q     <= phase_n;
				pend_kind_q <= pend_kind_n;
				left_q      <= left_n;
				acc_q       <= acc_n;
				held_len_q  <= held_len_n;
				pay_left_q  <= pay_left_n;
				out_valid_q <= res_valid;
			end else if (tokens.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_take && res_valid)
			out_q <= res;
	end

	assign tokens.valid      = out_valid_q;
	assign tokens.kind       = out_q.kind;
	assign tokens.length     = out_q.length;
	assign tokens.value_bits = out_q.value_bits;
	assign tokens.ext_code   = out_q.ext_code;
	assign tokens.chunk_byte = out_q.chunk_byte;
	assign tokens.chunk_last = out_q.chunk_last;
	assign tokens.bad_header = out_q.bad_header;

endmodule

// File: hw/rtl/msgpack_token_parser_core.sv
`timescale 1ns / 1ps
// Top level of the MessagePack token parser: front stage, queue, back end.
// Depends on mtp_pkg, mtp_bytes_if, mtp_tokens_if, mtp_front, mtp_fifo, mtp_back.

// Takes one MessagePack byte per beat on bytes and gives at most one token per
// byte on tokens. Sustained rate is one byte every clock while tokens are taken:
// the back end's parse state, 64-bit field shifter and payload counter all update
// once per byte. A token passes the front decode register, a queue slot and then
// the back end's output register after its last byte is accepted; a four-beat
// queue between the front stage and back end lets the input keep flowing while
// a token waits to be taken. Fixed forms come out at once, sized forms
// after their last length/value byte, and bin/str/ext payloads follow as one
// chunk token per byte with the final one marked. Byte 0xc1 gives a token with
// bad_header set and parsing carries on expecting a header.
module msgpack_token_parser_core (
	input  logic          clk,
	input  logic          arst_n,
	mtp_bytes_if.sink     bytes,
	mtp_tokens_if.source  tokens
);

	mtp_pkg::qbeat_t qpush;
	mtp_pkg::qbeat_t qpop;
	logic            q_ready;
	logic            q_take;

	mtp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes),
		.qpush   (qpush),
		.q_ready (q_ready)
	);

	mtp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (qpush),
		.wr_ready (q_ready),
		.rd       (qpop),
		.rd_take  (q_take)
	);

	mtp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (qpop),
		.rd_take (q_take),
		.tokens  (tokens)
	);

	// an accepted beat sits in the front register on the next cycle
	a_front_capture: assert property (@(posedge clk) disable iff (!arst_n)
		bytes.valid && bytes.ready |=> qpush.valid)
		else $error("accepted beat not held in front stage");

	// a full queue holds the front register still
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		qpush.valid && !q_ready |=> qpush.valid && $stable(qpush.entry))
		else $error("front stage changed while queue full");

	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && tokens.bad_header |->
			tokens.kind == mtp_pkg::K_NIL && tokens.length == 33'd0)
		else $error("error token carries fields");

	a_last_is_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && tokens.chunk_last |->
			tokens.kind == mtp_pkg::K_CHUNK && tokens.length == 33'd1)
		else $error("last mark on a non-chunk token");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for msgpack_token_parser_core: byte stream in, tokens out.
// Depends on mtp_pkg, mtp_bytes_if, mtp_tokens_if and the RTL of the parser.
module tb;

	localparam int RANDOM_BYTES = 900;
	localparam int DRAIN_PAD    = 16;
	localparam int IDLE_LIMIT   = 3000;
	localparam int HOLD_CYCLES  = 120;

	logic clk;
	logic arst_n;

	mtp_bytes_if  bytes_ch();
	mtp_tokens_if tok_ch();

	msgpack_token_parser_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes_ch),
		.tokens (tok_ch)
	);

	// parse state of the bench's own decoder
	mtp_pkg::phase_t ps_phase;
	mtp_pkg::kind_t  ps_kind;
	logic [3:0]      ps_left;
	logic [63:0]     ps_acc;
	logic [32:0]     ps_len;
	logic [31:0]     ps_pay;

	mtp_pkg::tok_t pending_tokens[$];

	bit no_gaps;
	int sink_hold;
	int bytes_sent;
	int tokens_checked;
	int failures;
	int input_stalls;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void open_payload(input logic [31:0] len);
		ps_pay   = len;
		ps_phase = (len != 0) ? mtp_pkg::PH_PAY : mtp_pkg::PH_HEAD;
	endfunction

	function automatic void start_field(input mtp_pkg::kind_t k, input logic [4:0] nbytes);
		ps_kind  = k;
		ps_left  = nbytes[3:0];
		ps_len   = 33'(nbytes);
		ps_acc   = '0;
		ps_phase = mtp_pkg::PH_FIELD;
	endfunction

	// Advances the decoder by one byte; returns 1 when the byte completes a token.
	function automatic bit decode_byte(input logic [7:0] b, output mtp_pkg::tok_t t);
		logic [31:0] len32;
		int sh;
		t = '0;
		case (ps_phase)
		mtp_pkg::PH_PAY: begin
			ps_pay = ps_pay - 32'd1;
			t.kind       = mtp_pkg::K_CHUNK;
			t.length     = 33'd1;
			t.chunk_byte = b;
			t.chunk_last = (ps_pay == 0);
			if (ps_pay == 0)
				ps_phase = mtp_pkg::PH_HEAD;
			return 1'b1;
		end
		mtp_pkg::PH_FIELD: begin
			ps_acc = {ps_acc[55:0], b};
			if (ps_left != 0)
				ps_left = ps_left - 4'd1;
			if (ps_left != 0)
				return 1'b0;
			ps_phase = mtp_pkg::PH_HEAD;
			if (ps_kind == mtp_pkg::K_UINT || ps_kind == mtp_pkg::K_SINT ||
					ps_kind == mtp_pkg::K_FLOAT) begin
				t.kind = ps_kind;
				// signed forms with a clear sign bit come out as unsigned
				if (ps_kind == mtp_pkg::K_SINT && ps_len >= 1 && ps_len <= 8) begin
					sh = 8 * int'(ps_len) - 1;
					if (ps_acc[sh] == 1'b0)
						t.kind = mtp_pkg::K_UINT;
				end
				t.length     = ps_len;
				t.value_bits = ps_acc;
				return 1'b1;
			end
			len32 = ps_acc[31:0];
			if (ps_kind == mtp_pkg::K_EXT) begin
				ps_len   = {1'b0, len32};
				ps_phase = mtp_pkg::PH_EXT;
				return 1'b0;
			end
			if (ps_kind == mtp_pkg::K_MAP) begin
				t.kind   = mtp_pkg::K_MAP;
				t.length = {len32, 1'b0};
				return 1'b1;
			end
			if (ps_kind == mtp_pkg::K_BIN || ps_kind == mtp_pkg::K_STR)
				open_payload(len32);
			t.kind   = ps_kind;
			t.length = {1'b0, len32};
			return 1'b1;
		end
		mtp_pkg::PH_EXT: begin
			len32 = ps_len[31:0];
			open_payload(len32);
			t.kind     = mtp_pkg::K_EXT;
			t.length   = {1'b0, len32};
			t.ext_code = b;
			return 1'b1;
		end
		default: ;
		endcase

		ps_phase = mtp_pkg::PH_HEAD;
		if (b < mtp_pkg::HDR_FIXMAP) begin
			t.kind       = mtp_pkg::K_UINT;
			t.length     = 33'd1;
			t.value_bits = 64'(b);
			return 1'b1;
		end
		if (b < mtp_pkg::HDR_FIXARRAY) begin
			t.kind   = mtp_pkg::K_MAP;
			t.length = 33'(b[3:0]) << 1;
			return 1'b1;
		end
		if (b < mtp_pkg::HDR_FIXSTR) begin
			t.kind   = mtp_pkg::K_ARRAY;
			t.length = 33'(b[3:0]);
			return 1'b1;
		end
		if (b < mtp_pkg::HDR_NIL) begin
			open_payload(32'(b[4:0]));
			t.kind   = mtp_pkg::K_STR;
			t.length = 33'(b[4:0]);
			return 1'b1;
		end
		if (b >= mtp_pkg::HDR_NEGFIX) begin
			t.kind       = mtp_pkg::K_SINT;
			t.length     = 33'd1;
			t.value_bits = 64'(b);
			return 1'b1;
		end
		if (b == mtp_pkg::HDR_NIL) begin
			t.kind = mtp_pkg::K_NIL;
			return 1'b1;
		end
		if (b == mtp_pkg::HDR_UNUSED) begin
			t.bad_header = 1'b1;
			return 1'b1;
		end
		if (b == mtp_pkg::HDR_FALSE || b == mtp_pkg::HDR_TRUE) begin
			t.kind       = mtp_pkg::K_BOOL;
			t.length     = 33'd1;
			t.value_bits = 64'(b[0]);
			return 1'b1;
		end
		if (b < mtp_pkg::HDR_EXT8)
			start_field(mtp_pkg::K_BIN, 5'd1 << (b - mtp_pkg::HDR_BIN8));
		else if (b < mtp_pkg::HDR_FLOAT32)
			start_field(mtp_pkg::K_EXT, 5'd1 << (b - mtp_pkg::HDR_EXT8));
		else if (b < mtp_pkg::HDR_UINT8)
			start_field(mtp_pkg::K_FLOAT, 5'd1 << (b - mtp_pkg::HDR_FLOAT_BASE));
		else if (b < mtp_pkg::HDR_INT8)
			start_field(mtp_pkg::K_UINT, 5'd1 << (b - mtp_pkg::HDR_UINT8));
		else if (b < mtp_pkg::HDR_FIXEXT1)
			start_field(mtp_pkg::K_SINT, 5'd1 << (b - mtp_pkg::HDR_INT8));
		else if (b < mtp_pkg::HDR_STR8) begin
			// fixext: length is in the header, type byte follows
			ps_kind  = mtp_pkg::K_EXT;
			ps_len   = 33'd1 << (b - mtp_pkg::HDR_FIXEXT1);
			ps_phase = mtp_pkg::PH_EXT;
		end else if (b < mtp_pkg::HDR_ARRAY16)
			start_field(mtp_pkg::K_STR, 5'd1 << (b - mtp_pkg::HDR_STR8));
		else if (b < mtp_pkg::HDR_MAP16)
			start_field(mtp_pkg::K_ARRAY, 5'd1 << (b - mtp_pkg::HDR_ARRAY_BASE));
		else
			start_field(mtp_pkg::K_MAP, 5'd1 << (b - mtp_pkg::HDR_MAP_BASE));
		return 1'b0;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		mtp_pkg::tok_t t;
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			bytes_ch.valid <= 1'b0;
		end
		@(negedge clk);
		bytes_ch.valid   <= 1'b1;
		bytes_ch.in_byte <= b;
		do
			@(posedge clk);
		while (bytes_ch.ready !== 1'b1);
		if (decode_byte(b, t))
			pending_tokens.push_back(t);
		bytes_sent++;
	endtask

	// Stop offering and let every expected token come out
	task automatic drain_tokens();
		@(negedge clk);
		bytes_ch.valid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic test_fixed_headers();
		send_byte(8'h00);
		send_byte(8'h7f);
		send_byte(mtp_pkg::HDR_FIXMAP);
		send_byte(mtp_pkg::HDR_FIXMAP | 8'h0f);
		send_byte(mtp_pkg::HDR_FIXARRAY);
		send_byte(mtp_pkg::HDR_FIXARRAY | 8'h0f);
		send_byte(mtp_pkg::HDR_FIXSTR);            // empty string, no chunks
		send_byte(mtp_pkg::HDR_NIL);
		send_byte(mtp_pkg::HDR_UNUSED);
		send_byte(mtp_pkg::HDR_FALSE);
		send_byte(mtp_pkg::HDR_TRUE);
		send_byte(mtp_pkg::HDR_NEGFIX);
		send_byte(8'hff);
		drain_tokens();
	endtask

	task automatic test_sized_edges();
		// map32 with the largest count: doubled into the 33rd bit
		send_byte(mtp_pkg::HDR_MAP_BASE + 8'd2);
		repeat (4) send_byte(8'hff);
		// int16 with sign clear comes out unsigned, int8 with sign set stays signed
		send_byte(mtp_pkg::HDR_INT8 + 8'd1);
		send_byte(8'h7f);
		send_byte(8'hff);
		send_byte(mtp_pkg::HDR_INT8);
		send_byte(8'h80);
		send_byte(mtp_pkg::HDR_BIN8);
		send_byte(8'h00);
		// fixext1: type byte then one payload beat, marked last
		send_byte(mtp_pkg::HDR_FIXEXT1);
		send_byte(8'h05);
		send_byte(8'haa);
		drain_tokens();
	endtask

	task automatic test_backpressure();
		int i;
		no_gaps   = 1'b1;
		sink_hold = HOLD_CYCLES;
		for (i = 0; i < 24; i++)
			send_byte(8'($urandom_range(0, 127)));
		no_gaps = 1'b0;
		drain_tokens();
	endtask

	task automatic test_random_stream();
		logic [7:0] b;
		int i;
		int r;
		for (i = 0; i < RANDOM_BYTES; i++) begin
			if (i % 100 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			b = 8'($urandom_range(0, 255));
			case (ps_phase)
			mtp_pkg::PH_HEAD: begin
				if (r >= 45)
					b = 8'($urandom_range(mtp_pkg::HDR_BIN8, mtp_pkg::HDR_NEGFIX - 8'd1));
			end
			mtp_pkg::PH_FIELD: begin
				if (ps_kind == mtp_pkg::K_BIN || ps_kind == mtp_pkg::K_STR ||
						ps_kind == mtp_pkg::K_EXT) begin
					// keep blob lengths short so payloads stay cheap
					if (ps_left == 1)
						b = (r < 85) ? 8'($urandom_range(0, 12)) : b;
					else if (ps_left == 2)
						b = (r < 5) ? 8'h01 : 8'h00;
					else
						b = 8'h00;
				end else if (r < 10)
					b = 8'h00;
				else if (r < 20)
					b = 8'hff;
			end
			default: ;
			endcase
			send_byte(b);
		end
		no_gaps = 1'b0;
		drain_tokens();
	endtask

	initial begin : token_sink
		int stall;
		stall = 0;
		tok_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				tok_ch.ready <= 1'b0;
				sink_hold--;
			end else if (stall > 0) begin
				tok_ch.ready <= 1'b0;
				stall--;
			end else begin
				tok_ch.ready <= 1'b1;
				if (!no_gaps)
					stall = pick_gap();
			end
		end
	end

	initial begin : token_checker
		mtp_pkg::tok_t want;
		mtp_pkg::tok_t got;
		forever begin
			@(posedge clk);
			if (tok_ch.valid === 1'b1 && tok_ch.ready === 1'b1) begin
				got = {tok_ch.kind, tok_ch.length, tok_ch.value_bits, tok_ch.ext_code,
					tok_ch.chunk_byte, tok_ch.chunk_last, tok_ch.bad_header};
				if (pending_tokens.size() == 0) begin
					if (failures < 10)
						$display("%0t: unexpected token kind=%0d len=%h val=%h", $realtime,
							got.kind, got.length, got.value_bits);
					failures++;
				end else begin
					want = pending_tokens.pop_front();
					if (got.kind !== want.kind || got.length !== want.length ||
							got.value_bits !== want.value_bits ||
							got.ext_code !== want.ext_code ||
							got.chunk_byte !== want.chunk_byte ||
							got.chunk_last !== want.chunk_last ||
							got.bad_header !== want.bad_header) begin
						if (failures < 10) begin
							$display({"%0t: token %0d expected kind=%0d len=%h val=%h",
								" ext=%h cb=%h last=%b bad=%b"},
								$realtime, tokens_checked, want.kind, want.length,
								want.value_bits, want.ext_code, want.chunk_byte,
								want.chunk_last, want.bad_header);
							$display({"%0t: token %0d actual   kind=%0d len=%h val=%h",
								" ext=%h cb=%h last=%b bad=%b"},
								$realtime, tokens_checked, got.kind, got.length,
								got.value_bits, got.ext_code, got.chunk_byte,
								got.chunk_last, got.bad_header);
						end
						failures++;
					end
				end
				tokens_checked++;
			end
		end
	end

	// Ends the run if neither channel moves a beat for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if (bytes_ch.valid === 1'b1 && bytes_ch.ready !== 1'b1)
				input_stalls++;
			if ((bytes_ch.valid === 1'b1 && bytes_ch.ready === 1'b1) ||
					(tok_ch.valid === 1'b1 && tok_ch.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no beat for %0d cycles, %0d tokens outstanding",
					IDLE_LIMIT, pending_tokens.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		arst_n           = 1'b0;
		bytes_ch.valid   = 1'b0;
		bytes_ch.in_byte = '0;
		no_gaps          = 1'b0;
		sink_hold        = 0;
		bytes_sent       = 0;
		tokens_checked   = 0;
		failures         = 0;
		input_stalls     = 0;
		ps_phase = mtp_pkg::PH_HEAD;
		ps_kind  = mtp_pkg::K_NIL;
		ps_left  = '0;
		ps_acc   = '0;
		ps_len   = '0;
		ps_pay   = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_fixed_headers();
		test_sized_edges();
		test_backpressure();
		test_random_stream();

		$display("Sent %0d stream bytes, checked %0d tokens (fixed, sized, blob, error).",
			bytes_sent, tokens_checked);
		$display("Parser held off the byte input for %0d cycles under token backpressure.",
			input_stalls);
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
